### hw/rtl/afc_pkg.sv
// Shared constants, types and helpers for the box frustum culling pipeline.
package afc_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int LANE_W      = 21;
	localparam int FIELD_W     = 63;
	localparam int IN_W        = 384;
	localparam int OUT_W       = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_W       = 64;
	localparam int W_W         = 44;   // world coordinate, 24 fraction bits
	localparam int PROD_W      = 58;   // normal times world coordinate
	localparam int DIST_W      = 60;   // plane distance, 36 fraction bits

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EYE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAXD = 3'd7;

	// cull reasons
	localparam logic [1:0] RSN_VISIBLE = 2'd0;
	localparam logic [1:0] RSN_PLANE   = 2'd1;
	localparam logic [1:0] RSN_FAR     = 2'd2;

	// world box plus running plane verdict, handed from cell to cell
	typedef struct packed {
		logic [2:0][W_W-1:0] wmin;
		logic [2:0][W_W-1:0] wmax;
		logic                outside;
	} afc_tok_t;

	// one signed 21-bit lane of a packed vector
	function automatic logic signed [LANE_W-1:0] lane(input logic [FIELD_W-1:0] v,
		input int idx);
		return $signed(v[LANE_W*idx +: LANE_W]);
	endfunction

endpackage

### hw/rtl/afc_xform.sv
// Corner transform: world-space box of the object in two stages.
module afc_xform import afc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic [IN_W-1:0] data_i,
	output logic            vld_o,
	output afc_tok_t        tok_o
);
	logic signed [41:0] pmin_s1 [3][3];
	logic signed [41:0] pmax_s1 [3][3];
	logic signed [36:0] t_s1 [3];
	logic               vld_s1;
	logic signed [W_W-1:0] lo [3][3];
	logic signed [W_W-1:0] hi [3][3];
	afc_tok_t           tok_d;

	// stage 1: products of each matrix entry with both corner coordinates
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int j = 0; j < 3; j++) begin
					pmin_s1[r][j] <= lane(data_i[FIELD_W*j +: FIELD_W], r)
						* lane(data_i[FIELD_W*4 +: FIELD_W], j);
					pmax_s1[r][j] <= lane(data_i[FIELD_W*j +: FIELD_W], r)
						* lane(data_i[FIELD_W*5 +: FIELD_W], j);
				end
				t_s1[r] <= {lane(data_i[FIELD_W*3 +: FIELD_W], r), 16'd0};
			end
		end
	end

	// stage 2: each term picks its own extreme, so row extremes are sums
	always_comb begin
		tok_d = '0;
		for (int r = 0; r < 3; r++) begin
			for (int j = 0; j < 3; j++) begin
				if (pmin_s1[r][j] < pmax_s1[r][j]) begin
					lo[r][j] = W_W'(pmin_s1[r][j]);
					hi[r][j] = W_W'(pmax_s1[r][j]);
				end else begin
					lo[r][j] = W_W'(pmax_s1[r][j]);
					hi[r][j] = W_W'(pmin_s1[r][j]);
				end
			end
			tok_d.wmin[r] = lo[r][0] + lo[r][1] + lo[r][2] + W_W'(t_s1[r]);
			tok_d.wmax[r] = hi[r][0] + hi[r][1] + hi[r][2] + W_W'(t_s1[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) tok_o <= tok_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_o  <= vld_s1;
		end
	end

endmodule

### hw/rtl/afc_plane_cell.sv
// One plane of the frustum: positive-vertex test, two stages per cell.
module afc_plane_cell import afc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [CFG_W-1:0] plane,
	input  logic             vld_i,
	input  afc_tok_t         tok_i,
	output logic             vld_o,
	output afc_tok_t         tok_o
);
	logic signed [PROD_W-1:0] prod_s1 [3];
	afc_tok_t                 tok_s1;
	logic                     vld_s1;
	logic signed [13:0]       nrm [3];
	logic signed [DIST_W-1:0] pdist;
	afc_tok_t                 tok_d;

	// stage 1: normal times the box corner farthest along it
	always_comb begin
		for (int r = 0; r < 3; r++) nrm[r] = $signed(plane[14*r +: 14]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r] <= nrm[r] * (nrm[r][13] ? $signed(tok_i.wmin[r])
					: $signed(tok_i.wmax[r]));
			end
			tok_s1 <= tok_i;
		end
	end

	// stage 2: add offset, strictly negative means outside
	always_comb begin
		pdist = DIST_W'($signed({plane[63:42], 28'd0})) + DIST_W'(prod_s1[0])
			+ DIST_W'(prod_s1[1]) + DIST_W'(prod_s1[2]);
		tok_d = tok_s1;
		tok_d.outside = tok_s1.outside | pdist[DIST_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) tok_o <= tok_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_o  <= vld_s1;
		end
	end

endmodule

### hw/rtl/afc_dist.sv
// Eye distance test and final reason, four stages.
module afc_dist import afc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [FIELD_W-1:0] eye,
	input  logic [19:0]        maxd,
	input  logic               vld_i,
	input  afc_tok_t           tok_i,
	output logic               vld_o,
	output logic [1:0]         reason_o
);
	logic [35:0] v_s1 [3];
	logic        big_s1, out_s1, on_s1, vld_s1;
	logic [19:0] md_s1;
	logic [35:0] hh_s2 [3];
	logic [35:0] hl_s2 [3];
	logic [35:0] ll_s2 [3];
	logic [39:0] m2_s2;
	logic        big_s2, out_s2, on_s2, vld_s2;
	logic [73:0] sq_s3;
	logic [71:0] lim_s3;
	logic        big_s3, out_s3, on_s3, vld_s3;
	logic signed [36:0] e [3];
	logic [43:0] v [3];
	logic        big;
	logic [73:0] sq;

	// stage 1: per-axis gap from eye to box, clipped when already huge
	always_comb begin
		big = 1'b0;
		for (int r = 0; r < 3; r++) begin
			e[r] = {lane(eye, r), 16'd0};
			if (e[r] < $signed(tok_i.wmin[r]))
				v[r] = tok_i.wmin[r] - W_W'(e[r]);
			else if (e[r] > $signed(tok_i.wmax[r]))
				v[r] = W_W'(e[r]) - tok_i.wmax[r];
			else
				v[r] = '0;
			big = big | (v[r][43:36] != 8'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) v_s1[r] <= v[r][35:0];
			big_s1 <= big;
			out_s1 <= tok_i.outside;
			on_s1  <= (maxd != 20'd0);
			md_s1  <= maxd;
		end
	end

	// stage 2: 18-bit partial squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				hh_s2[r] <= v_s1[r][35:18] * v_s1[r][35:18];
				hl_s2[r] <= v_s1[r][35:18] * v_s1[r][17:0];
				ll_s2[r] <= v_s1[r][17:0] * v_s1[r][17:0];
			end
			m2_s2  <= md_s1 * md_s1;
			big_s2 <= big_s1;
			out_s2 <= out_s1;
			on_s2  <= on_s1;
		end
	end

	// stage 3: squared distance and limit at 48 fraction bits
	always_comb begin
		sq = '0;
		for (int r = 0; r < 3; r++) begin
			sq = sq + {2'd0, hh_s2[r], 36'd0} + {19'd0, hl_s2[r], 19'd0}
				+ {38'd0, ll_s2[r]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3  <= sq;
			lim_s3 <= {m2_s2, 32'd0};
			big_s3 <= big_s2;
			out_s3 <= out_s2;
			on_s3  <= on_s2;
		end
	end

	// stage 4: compare, planes take precedence
	always_ff @(posedge clk) begin
		if (en) begin
			priority if (out_s3)
				reason_o <= RSN_PLANE;
			else if (on_s3 && (big_s3 || sq_s3 > {2'd0, lim_s3}))
				reason_o <= RSN_FAR;
			else
				reason_o <= RSN_VISIBLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_o  <= vld_s3;
		end
	end

endmodule

### hw/rtl/aabb_frustum_cull.sv
// Top level: box transform, chain of plane cells, distance test, output skid.
// Throughput: one object per cycle; the pipeline halts only while the skid holds a result.
// The pipeline is 2 transform stages, 2 stages per plane cell, 4 distance stages.
// Reset (arst_n low, asynchronous) clears all valid bits, including the output and skid valid bits,
// and every configuration register to zero; the result data registers are not reset.
module aabb_frustum_cull import afc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// fields from bit 0: matrix_column_x, matrix_column_y, matrix_column_z,
	// matrix_translation, box_min, box_max (63 bits each), zero pad
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// fields from bit 0: culled, cull_reason[1:0], zero pad
	output logic [OUT_W-1:0]     m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);
	logic [CFG_W-1:0]   plane_q [PLANE_COUNT];
	logic [FIELD_W-1:0] eye_q;
	logic [19:0]        maxd_q;
	logic               en;
	logic               vld_c [PLANE_COUNT+1];
	afc_tok_t           tok_c [PLANE_COUNT+1];
	logic               fin_vld;
	logic [1:0]         fin_reason;
	logic               out_vld_q, skid_vld_q;
	logic [1:0]         out_reason_q, skid_reason_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PLANE_COUNT; k++) plane_q[k] <= '0;
			eye_q  <= '0;
			maxd_q <= '0;
		end else if (cfg_we) begin
			for (int k = 0; k < PLANE_COUNT; k++) begin
				if (cfg_idx == CFG_IDX_W'(k)) plane_q[k] <= cfg_data;
			end
			if (cfg_idx == REG_EYE)  eye_q  <= cfg_data[FIELD_W-1:0];
			if (cfg_idx == REG_MAXD) maxd_q <= cfg_data[19:0];
		end
	end

	// pipeline moves whenever the skid is empty
	assign en       = !skid_vld_q;
	assign s_tready = en;

	afc_xform u_xform (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (s_tvalid),
		.data_i (s_tdata),
		.vld_o  (vld_c[0]),
		.tok_o  (tok_c[0])
	);

	for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
		afc_plane_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.plane  (plane_q[k]),
			.vld_i  (vld_c[k]),
			.tok_i  (tok_c[k]),
			.vld_o  (vld_c[k+1]),
			.tok_o  (tok_c[k+1])
		);
	end

	afc_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.eye      (eye_q),
		.maxd     (maxd_q),
		.vld_i    (vld_c[PLANE_COUNT]),
		.tok_i    (tok_c[PLANE_COUNT]),
		.vld_o    (fin_vld),
		.reason_o (fin_reason)
	);

	// output register with one-entry skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= fin_vld;
			end
		end else if (fin_vld && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			out_reason_q <= skid_vld_q ? skid_reason_q : fin_reason;
		end else if (fin_vld && en) begin
			skid_reason_q <= fin_reason;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'd0, out_reason_q, out_reason_q != RSN_VISIBLE};

endmodule

### hw/rtl/afc_checker.sv
// Port-level checks for the culling block, bound to the top level.
module afc_checker import afc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// culled flag agrees with the reason
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[0] == (m_tdata[2:1] != RSN_VISIBLE))
		else $error("culled flag disagrees with reason");

	// no unused reason code and clean padding
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:1] != 2'd3 && m_tdata[7:3] == 5'd0)
		else $error("bad reason code or padding");

	// with no result waiting the input side is always open
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/tb_aabb_frustum_cull.sv
// Self-checking testbench for the box frustum culling pipeline.
`timescale 1ns / 100ps

module tb_aabb_frustum_cull;
	import afc_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 25;
	localparam int RAND_PER_SET = 160;

	// Predicts the cull verdict of each accepted object and compares results in order
	class cull_scoreboard;
		logic [63:0] planes [PLANE_COUNT];
		logic [62:0] eye;
		logic [19:0] far_limit;
		logic [1:0]  pending_reasons [$];
		int          mismatches;

		function new();
			foreach (planes[k]) planes[k] = '0;
			eye = '0;
			far_limit = '0;
			mismatches = 0;
		endfunction

		function void write_reg(int idx, logic [CFG_W-1:0] val);
			if (idx < PLANE_COUNT) planes[idx] = val;
			else if (idx == REG_EYE) eye = val[62:0];
			else if (idx == REG_MAXD) far_limit = val[19:0];
		endfunction

		function longint sx(logic [63:0] v, int w);
			logic signed [63:0] tmp;
			tmp = v << (64 - w);
			return tmp >>> (64 - w);
		endfunction

		// transform the 8 corners, bound them, then plane and distance tests
		function void note_object(logic [IN_W-1:0] d);
			longint mat [3][3];
			longint tr [3], lmin [3], lmax [3], lc [3], wmin [3], wmax [3];
			longint w, pdist, n, e;
			logic [127:0] dsq, lim, v, md;
			logic [1:0] reason;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) mat[c][r] = sx(d[63*c + 21*r +: 21], 21);
				tr[r]   = sx(d[63*3 + 21*r +: 21], 21) * 65536;
				lmin[r] = sx(d[63*4 + 21*r +: 21], 21);
				lmax[r] = sx(d[63*5 + 21*r +: 21], 21);
			end
			for (int c = 0; c < 8; c++) begin
				lc[0] = c[0] ? lmax[0] : lmin[0];
				lc[1] = c[1] ? lmax[1] : lmin[1];
				lc[2] = c[2] ? lmax[2] : lmin[2];
				for (int r = 0; r < 3; r++) begin
					w = mat[0][r] * lc[0] + mat[1][r] * lc[1] + mat[2][r] * lc[2] + tr[r];
					if (c == 0 || w < wmin[r]) wmin[r] = w;
					if (c == 0 || w > wmax[r]) wmax[r] = w;
				end
			end
			reason = RSN_VISIBLE;
			for (int k = 0; k < PLANE_COUNT; k++) begin
				if (reason == RSN_VISIBLE) begin
					pdist = sx(planes[k] >> 42, 22) * (longint'(1) << 28);
					for (int r = 0; r < 3; r++) begin
						n = sx(planes[k] >> (14 * r), 14);
						pdist += n * (n >= 0 ? wmax[r] : wmin[r]);
					end
					if (pdist < 0) reason = RSN_PLANE;
				end
			end
			if (reason == RSN_VISIBLE && far_limit != 0) begin
				dsq = '0;
				for (int r = 0; r < 3; r++) begin
					e = sx(eye >> (21 * r), 21) * 65536;
					v = '0;
					if (e < wmin[r]) v[63:0] = wmin[r] - e;
					else if (e > wmax[r]) v[63:0] = e - wmax[r];
					dsq += v * v;
				end
				md = 128'(far_limit) << 16;
				lim = md * md;
				if (dsq > lim) reason = RSN_FAR;
			end
			pending_reasons.push_back(reason);
		endfunction

		function void check_result(logic [OUT_W-1:0] d);
			logic [1:0] exp_reason;
			if (pending_reasons.size() == 0) begin
				$error("result with nothing pending: culled=%0d reason=%0d", d[0], d[2:1]);
				mismatches++;
				return;
			end
			exp_reason = pending_reasons.pop_front();
			if (d[0] !== (exp_reason != RSN_VISIBLE)) begin
				$error("culled: expected %0d, actual %0d", exp_reason != RSN_VISIBLE, d[0]);
				mismatches++;
			end
			if (d[2:1] !== exp_reason) begin
				$error("cull_reason: expected %0d, actual %0d", exp_reason, d[2:1]);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;   // matrix_column_x/y/z, matrix_translation, box_min, box_max
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;   // culled, cull_reason[1:0]
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	cull_scoreboard sb;
	logic hold_req;
	int   idle_cycles;

	aabb_frustum_cull u_top (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// transfer monitor and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_object(s_tdata);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// receiver: changing stall patterns, plus one long hold-off on request
	initial begin
		int mode;
		int span;
		m_tready = 1'b0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 60);
			repeat (span) begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= $urandom_range(0, 1);
				endcase
				@(posedge clk);
			end
		end
	end

	// hand one object to the block, waiting for its transfer
	task automatic send_object(logic [IN_W-1:0] obj);
		s_tvalid <= 1'b1;
		s_tdata  <= obj;
		do @(posedge clk); while (!s_tready);
	endtask

	// sender bursts: drop valid for a random gap now and then
	task automatic maybe_gap();
		int gap;
		if ($urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_all(logic [CFG_W-1:0] vals [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			sb.write_reg(i, vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_reasons.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] mk_plane(int nx, int ny, int nz, int d);
		logic [CFG_W-1:0] p;
		p = '0;
		p[13:0]  = nx[13:0];
		p[27:14] = ny[13:0];
		p[41:28] = nz[13:0];
		p[63:42] = d[21:0];
		return p;
	endfunction

	function automatic logic [20:0] rand_lane(bit narrow);
		int sh;
		int v;
		if (!narrow) return 21'($urandom());
		sh = $urandom_range(2, 20);
		v = $urandom_range(0, (1 << sh) - 1) - (1 << (sh - 1));
		return v[20:0];
	endfunction

	// object with random content; half of them well-formed boxes with near-unit matrices
	function automatic logic [IN_W-1:0] rand_object();
		logic [IN_W-1:0] obj;
		int kind;
		int lo, hi;
		obj = '0;
		kind = $urandom_range(0, 3);
		for (int r = 0; r < 3; r++) begin
			for (int f = 0; f < 6; f++) obj[63*f + 21*r +: 21] = rand_lane(kind != 0);
			if (kind >= 2) begin
				for (int c = 0; c < 3; c++)
					obj[63*c + 21*r +: 21] = (c == r) ? 21'(65536 + $urandom_range(0, 8191)
						- 4096) : 21'($urandom_range(0, 8191) - 4096);
				lo = $urandom_range(0, 8191) - 4096;
				hi = lo + $urandom_range(0, 4096);
				obj[63*4 + 21*r +: 21] = lo[20:0];
				obj[63*5 + 21*r +: 21] = hi[20:0];
			end
		end
		return obj;
	endfunction

	function automatic logic [IN_W-1:0] fill_lanes(int f_lo, int f_hi, logic [20:0] val);
		logic [IN_W-1:0] obj;
		obj = '0;
		for (int f = f_lo; f <= f_hi; f++)
			for (int r = 0; r < 3; r++) obj[63*f + 21*r +: 21] = val;
		return obj;
	endfunction

	function automatic logic [IN_W-1:0] unit_box(int lo, int hi);
		logic [IN_W-1:0] obj;
		obj = fill_lanes(4, 4, lo[20:0]) | fill_lanes(5, 5, hi[20:0]);
		for (int r = 0; r < 3; r++) obj[63*r + 21*r +: 21] = 21'd65536;
		return obj;
	endfunction

	task automatic run_random(int count, bit with_hold);
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == 20) hold_req = 1'b1;
			send_object(rand_object());
			if (!(with_hold && i >= 20 && i < 80)) maybe_gap();
		end
	endtask

	initial begin
		logic [CFG_W-1:0] regs [8];
		logic [IN_W-1:0]  ones;
		sb = new();
		hold_req = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: everything visible
		send_object('0);
		run_random(40, 1'b0);
		drain();

		// left plane touching x = 0, right plane x <= 8.0, distance limit 16.0
		regs[0] = mk_plane(4096, 0, 0, 0);
		regs[1] = mk_plane(-4096, 0, 0, 2048);
		regs[2] = mk_plane(0, 0, 0, 1);
		regs[3] = mk_plane(0, 0, 0, 1);
		regs[4] = mk_plane(0, 0, 0, 0);
		regs[5] = mk_plane(0, 0, 0, 1);
		regs[6] = '0;
		regs[7] = 64'd4096;
		write_all(regs);
		ones = fill_lanes(0, 5, '1);
		send_object('0);                                   // point at origin, touching
		send_object(ones);                                 // all field bits set
		send_object(fill_lanes(0, 5, 21'h0FFFFF));         // largest positive lanes
		send_object(fill_lanes(0, 5, 21'h100000));         // most negative lanes
		send_object(unit_box(0, 256));                     // inside, on left plane
		send_object(unit_box(-256, -1));                   // behind left plane
		send_object(unit_box(256, 0));                     // min above max
		send_object(unit_box(2048, 2304));                 // touches right plane
		send_object(unit_box(2049, 2304));                 // beyond right plane
		send_object(unit_box(1000, 1100));                 // well inside distance limit
		send_object(unit_box(2400, 2500));                 // plane and distance fail
		send_object(fill_lanes(3, 3, 21'd4000) | unit_box(0, 0)); // beyond right plane and far, by translation
		drain();

		// planes all ones: normal -1/4096 each, offset just below zero
		foreach (regs[i]) regs[i] = '1;
		write_all(regs);
		send_object('0);
		send_object(ones);
		run_random(RAND_PER_SET, 1'b1);
		drain();

		// wide-open planes, random eye and tight random distance limit
		for (int k = 0; k < PLANE_COUNT; k++)
			regs[k] = mk_plane(0, 0, 0, $urandom_range(0, 32'h1FFFFF));
		regs[6] = {$urandom(), $urandom()};
		regs[7] = 64'($urandom_range(1, 4096));
		write_all(regs);
		run_random(RAND_PER_SET, 1'b0);
		drain();

		// random bounded frustum with some inactive planes
		for (int k = 0; k < PLANE_COUNT; k++)
			regs[k] = ($urandom_range(0, 2) == 0) ? mk_plane(0, 0, 0, 100) :
				mk_plane($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
					$urandom_range(0, 8191) - 4096, $urandom_range(0, 8191));
		regs[6] = {$urandom(), $urandom()} & 64'h0000_3FFF_8000_3FFF;
		regs[7] = 64'($urandom_range(1, 32'hFFFFF));
		write_all(regs);
		run_random(RAND_PER_SET, 1'b0);
		drain();

		// fully random registers
		foreach (regs[i]) regs[i] = {$urandom(), $urandom()};
		write_all(regs);
		run_random(RAND_PER_SET, 1'b0);
		drain();

		// largest distance limit with open planes, then all zero
		for (int k = 0; k < PLANE_COUNT; k++) regs[k] = mk_plane(0, 0, 0, 32'h1FFFFF);
		regs[6] = {1'b0, 21'h100000, 21'h0FFFFF, 21'h100000};
		regs[7] = 64'hFFFFF;
		write_all(regs);
		send_object(ones);
		run_random(RAND_PER_SET / 2, 1'b0);
		drain();
		foreach (regs[i]) regs[i] = '0;
		write_all(regs);
		run_random(RAND_PER_SET / 2, 1'b0);
		drain();

		if (sb.mismatches == 0 && sb.pending_reasons.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### aabb_frustum_cull.f
hw/rtl/afc_pkg.sv
hw/rtl/afc_xform.sv
hw/rtl/afc_plane_cell.sv
hw/rtl/afc_dist.sv
hw/rtl/aabb_frustum_cull.sv
hw/rtl/afc_checker.sv
tb/tb_aabb_frustum_cull.sv
